// ----- sv/ccb_pkg.sv -----
package ccb_pkg;

    localparam int MAP_BITS  = 256;
    localparam int WORD_BITS = 64;
    localparam int NUM_CELLS = MAP_BITS / WORD_BITS;
    localparam int IDX_BITS  = $clog2(NUM_CELLS);

    // Character codes the parser and the cells look for
    localparam logic [7:0] CH_OPEN    = 8'h5B; // [
    localparam logic [7:0] CH_CLOSE   = 8'h5D; // ]
    localparam logic [7:0] CH_LBRACE  = 8'h7B; // {
    localparam logic [7:0] CH_RBRACE  = 8'h7D; // }
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_N       = 8'h6E;
    localparam logic [7:0] CH_R       = 8'h72;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_A       = 8'h61;
    localparam logic [7:0] CH_B       = 8'h62;
    localparam logic [7:0] CH_F       = 8'h66;
    localparam logic [7:0] CH_V       = 8'h76;
    localparam logic [7:0] CH_S       = 8'h73;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_W       = 8'h77;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] NEWLINE    = 8'h0A;
    localparam logic [7:0] CARRIAGE   = 8'h0D;
    localparam logic [7:0] HTAB       = 8'h09;
    localparam logic [7:0] BELL       = 8'h07;
    localparam logic [7:0] BACKSPACE  = 8'h08;
    localparam logic [7:0] FORMFEED   = 8'h0C;
    localparam logic [7:0] VTAB       = 8'h0B;
    localparam logic [7:0] SPACE      = 8'h20;
    localparam logic [7:0] DIGIT_LO   = 8'd48;
    localparam logic [7:0] DIGIT_HI   = 8'd57;
    localparam logic [7:0] UPPER_LO   = 8'd65;
    localparam logic [7:0] UPPER_HI   = 8'd90;
    localparam logic [7:0] LOWER_LO   = 8'd97;
    localparam logic [7:0] LOWER_HI   = 8'd122;

    localparam logic [8:0] OPEN_MARK  = 9'd256;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_UNBALANCED = 2'd1,
        STATUS_BRACE      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        HEX_IDLE   = 2'd0,
        HEX_FIRST  = 2'd1,
        HEX_SECOND = 2'd2,
        HEX_BAD    = 2'd3
    } hex_phase_t;

    typedef enum logic [2:0] {
        OUT_MAP,
        OUT_INV,
        OUT_ALL,
        OUT_DOT,
        OUT_ZERO
    } out_mode_t;

    // Update request broadcast from the parser to every map cell
    typedef struct packed {
        logic       upd;
        logic       load;
        logic       lit_en;
        logic [7:0] lit_ch;
        logic       range_en;
        logic [7:0] range_lo;
        logic       cls_s;
        logic       cls_d;
        logic       cls_w;
        out_mode_t  mode;
    } ccb_req_t;

endpackage

// ----- sv/ccb_parse.sv -----
module ccb_parse
    import ccb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] symbol,
    input  logic       final_symbol,
    output ccb_req_t   req,
    output status_t    status
);

    // Hex digit decode: bit 4 marks a valid digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    logic       esc_reg, esc_next;
    logic       rng_reg, rng_next;
    logic [8:0] prev_reg, prev_next;
    logic [7:0] rb_reg, rb_next;
    logic       inv_reg, inv_next;
    logic [15:0] dep_reg, dep_next;
    hex_phase_t hph_reg, hph_next;
    logic [7:0] hval_reg, hval_next;
    logic [7:0] first_reg;
    logic [1:0] len_reg;

    logic       is_first;
    logic [7:0] first_eff;
    logic       special_star;
    logic       special_dot;
    logic [4:0] hd;
    logic [7:0] esc_code;

    assign is_first     = (len_reg == 2'd0);
    assign first_eff    = is_first ? symbol : first_reg;
    assign special_star = final_symbol && is_first && (symbol == CH_STAR);
    assign special_dot  = final_symbol && is_first && (symbol == CH_DOT);
    assign hd           = hex_digit(symbol);

    // Control escape letter to its code
    always_comb begin
        unique case (symbol)
            CH_N:    esc_code = NEWLINE;
            CH_R:    esc_code = CARRIAGE;
            CH_T:    esc_code = HTAB;
            CH_A:    esc_code = BELL;
            CH_B:    esc_code = BACKSPACE;
            CH_F:    esc_code = FORMFEED;
            default: esc_code = VTAB;
        endcase
    end

    // Decode one byte into next state and a map update request
    always_comb begin
        esc_next     = esc_reg;
        rng_next     = rng_reg;
        prev_next    = prev_reg;
        rb_next      = rb_reg;
        inv_next     = inv_reg;
        dep_next     = dep_reg;
        hph_next     = hph_reg;
        hval_next    = hval_reg;
        req          = '0;
        req.lit_ch   = symbol;
        req.range_en = rng_reg;
        req.range_lo = rb_reg;
        req.mode     = OUT_MAP;
        status       = STATUS_OK;

        if (!(special_star || special_dot)) begin
            if (hph_reg == HEX_FIRST) begin
                if (hd[4]) begin
                    hval_next = {4'd0, hd[3:0]};
                    hph_next  = HEX_SECOND;
                end else begin
                    hval_next = 8'd0;
                    hph_next  = HEX_BAD;
                end
            end else if (hph_reg != HEX_IDLE) begin
                if (hph_reg == HEX_SECOND && hd[4]) begin
                    hval_next = {hval_reg[3:0], hd[3:0]};
                end
                hph_next    = HEX_IDLE;
                req.lit_en  = 1'b1;
                req.lit_ch  = hval_next;
                rng_next    = 1'b0;
                prev_next   = {1'b0, hval_next};
            end else begin
                unique case (symbol)
                    CH_OPEN: begin
                        if (esc_reg) begin
                            req.lit_en = 1'b1;
                            rng_next   = 1'b0;
                            prev_next  = {1'b0, symbol};
                            esc_next   = 1'b0;
                        end else begin
                            prev_next = OPEN_MARK;
                            dep_next  = dep_reg + 16'd1;
                        end
                    end
                    CH_CLOSE: begin
                        if (esc_reg) begin
                            req.lit_en = 1'b1;
                            rng_next   = 1'b0;
                            prev_next  = {1'b0, symbol};
                            esc_next   = 1'b0;
                        end else begin
                            dep_next = dep_reg - 16'd1;
                        end
                    end
                    CH_LBRACE, CH_RBRACE: begin
                        req.lit_en = 1'b1;
                        rng_next   = 1'b0;
                        prev_next  = {1'b0, symbol};
                    end
                    CH_BSLASH: begin
                        if (esc_reg) begin
                            req.lit_en = 1'b1;
                            rng_next   = 1'b0;
                            prev_next  = {1'b0, symbol};
                            esc_next   = 1'b0;
                        end else begin
                            esc_next = 1'b1;
                        end
                    end
                    CH_N, CH_R, CH_T, CH_A, CH_B, CH_F, CH_V: begin
                        req.lit_en = 1'b1;
                        rng_next   = 1'b0;
                        if (esc_reg) begin
                            req.lit_ch = esc_code;
                            prev_next  = {1'b0, esc_code};
                            esc_next   = 1'b0;
                        end else begin
                            prev_next = {1'b0, symbol};
                        end
                    end
                    CH_SQUOTE, CH_DQUOTE: begin
                        req.lit_en = 1'b1;
                        rng_next   = 1'b0;
                        prev_next  = {1'b0, symbol};
                        esc_next   = 1'b0;
                    end
                    CH_DASH: begin
                        if (esc_reg || prev_reg == OPEN_MARK) begin
                            req.lit_en = 1'b1;
                            rng_next   = 1'b0;
                            prev_next  = {1'b0, symbol};
                            esc_next   = 1'b0;
                        end else begin
                            rng_next = 1'b1;
                            rb_next  = prev_reg[7:0];
                        end
                    end
                    CH_S, CH_D, CH_W: begin
                        if (esc_reg) begin
                            req.cls_s = (symbol == CH_S);
                            req.cls_d = (symbol == CH_D);
                            req.cls_w = (symbol == CH_W);
                            esc_next  = 1'b0;
                        end else begin
                            req.lit_en = 1'b1;
                            rng_next   = 1'b0;
                            prev_next  = {1'b0, symbol};
                        end
                    end
                    CH_CARET: begin
                        if (esc_reg) begin
                            req.lit_en = 1'b1;
                            rng_next   = 1'b0;
                            prev_next  = {1'b0, symbol};
                            esc_next   = 1'b0;
                        end else begin
                            inv_next = 1'b1;
                        end
                    end
                    CH_X: begin
                        if (esc_reg) begin
                            esc_next  = 1'b0;
                            hph_next  = HEX_FIRST;
                            hval_next = 8'd0;
                        end else begin
                            req.lit_en = 1'b1;
                            rng_next   = 1'b0;
                            prev_next  = {1'b0, symbol};
                        end
                    end
                    default: begin
                        esc_next   = 1'b0;
                        req.lit_en = 1'b1;
                        rng_next   = 1'b0;
                        prev_next  = {1'b0, symbol};
                    end
                endcase
            end

            // Complete a hex escape cut off by the end of the string
            if (final_symbol && hph_next != HEX_IDLE) begin
                req.lit_en = 1'b1;
                req.lit_ch = (hph_next == HEX_SECOND) ? hval_next : 8'd0;
            end
        end

        // Pick the form of the emitted map
        if (special_star) begin
            req.mode = OUT_ALL;
        end else if (special_dot) begin
            req.mode = OUT_DOT;
        end else if (first_eff == CH_LBRACE && symbol == CH_RBRACE) begin
            req.mode = OUT_ZERO;
            status   = STATUS_BRACE;
        end else if (dep_next != 16'd0) begin
            req.mode = OUT_ZERO;
            status   = STATUS_UNBALANCED;
        end else if (inv_next) begin
            req.mode = OUT_INV;
        end

        req.upd  = accept && !(special_star || special_dot);
        req.load = accept && final_symbol;
    end

    // Hold parser state; return to reset after the last byte
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && final_symbol)) begin
            esc_reg   <= 1'b0;
            rng_reg   <= 1'b0;
            prev_reg  <= 9'd0;
            rb_reg    <= 8'd0;
            inv_reg   <= 1'b0;
            dep_reg   <= 16'd0;
            hph_reg   <= HEX_IDLE;
            hval_reg  <= 8'd0;
            first_reg <= 8'd0;
            len_reg   <= 2'd0;
        end else if (accept) begin
            esc_reg   <= esc_next;
            rng_reg   <= rng_next;
            prev_reg  <= prev_next;
            rb_reg    <= rb_next;
            inv_reg   <= inv_next;
            dep_reg   <= dep_next;
            hph_reg   <= hph_next;
            hval_reg  <= hval_next;
            first_reg <= first_eff;
            if (len_reg != 2'd2) begin
                len_reg <= len_reg + 2'd1;
            end
        end
    end

endmodule

// ----- sv/ccb_cell.sv -----
module ccb_cell
    import ccb_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ccb_req_t             req,
    input  logic                 shift,
    input  logic [WORD_BITS-1:0] shift_in,
    output logic [WORD_BITS-1:0] word_out
);

    logic [WORD_BITS-1:0] acc_reg;
    logic [WORD_BITS-1:0] out_reg;
    logic [WORD_BITS-1:0] merged;
    logic [WORD_BITS-1:0] snap;

    // Compare every byte value of this quarter against the request
    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            logic [7:0] v;
            logic       hit;
            logic       dot_bit;
            v   = 8'(CELL_IDX * WORD_BITS + j);
            hit = 1'b0;
            if (req.lit_en && v == req.lit_ch) begin
                hit = 1'b1;
            end
            if (req.lit_en && req.range_en && v >= req.range_lo && v <= req.lit_ch) begin
                hit = 1'b1;
            end
            if (req.cls_s && ((v >= HTAB && v <= CARRIAGE) || v == SPACE)) begin
                hit = 1'b1;
            end
            if ((req.cls_d || req.cls_w) && v >= DIGIT_LO && v <= DIGIT_HI) begin
                hit = 1'b1;
            end
            if (req.cls_w && ((v >= UPPER_LO && v <= UPPER_HI) ||
                              (v >= LOWER_LO && v <= LOWER_HI) || v == CH_UNDER)) begin
                hit = 1'b1;
            end
            merged[j] = acc_reg[j] | (req.upd & hit);
            dot_bit   = (v != NEWLINE);
            unique case (req.mode)
                OUT_MAP:  snap[j] = merged[j];
                OUT_INV:  snap[j] = ~merged[j];
                OUT_ALL:  snap[j] = 1'b1;
                OUT_DOT:  snap[j] = dot_bit;
                default:  snap[j] = 1'b0;
            endcase
        end
    end

    // Accumulate the map; clear it when a string ends
    always_ff @(posedge aclk) begin
        if (!aresetn || req.load) begin
            acc_reg <= '0;
        end else if (req.upd) begin
            acc_reg <= merged;
        end
    end

    // Load the finished quarter or take the neighbor's word
    always_ff @(posedge aclk) begin
        if (req.load) begin
            out_reg <= snap;
        end else if (shift) begin
            out_reg <= shift_in;
        end
    end

    assign word_out = out_reg;

endmodule

// ----- sv/char_class_to_bitmap_top.sv -----
// Channel  | Ports                       | Contents
// input    | s_tvalid s_tready s_tdata   | tdata[7:0] symbol, tlast final_symbol
//          | s_tlast                     |
// result   | m_tvalid m_tready m_tdata   | tdata[63:0] map_word, tuser[1:0] word_index,
//          | m_tuser m_tlast             | tuser[3:2] status, tlast last_word
//
// One byte is taken per cycle; the map cells apply its update in that same cycle.
// A last byte loads four words into the cell chain, which unloads one word per cycle
// from cell 0 while m_tready is high, so a string yields its map as four result words.
// A last byte waits until the chain is empty or its last word is taken in that cycle;
// other bytes are taken regardless of the result side.
// Reset clears the parser, the maps and the result valid; no clearing pass.
module char_class_to_bitmap_top
    import ccb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] symbol
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [WORD_BITS-1:0] m_tdata,   // [63:0] map_word
    output logic [3:0]           m_tuser,   // [1:0] word_index, [3:2] status
    output logic                 m_tlast
);

    ccb_req_t              req;
    status_t               status;
    status_t               status_reg;
    logic                  out_valid_reg;
    logic [IDX_BITS-1:0]   out_idx_reg;
    logic                  accept;
    logic                  shift;
    logic                  drain_last;
    logic [WORD_BITS-1:0]  chain_w [0:NUM_CELLS];

    assign shift      = out_valid_reg && m_tready;
    assign drain_last = shift && (out_idx_reg == IDX_BITS'(NUM_CELLS - 1));
    assign s_tready   = !s_tlast || !out_valid_reg || drain_last;
    assign accept     = s_tvalid && s_tready;

    ccb_parse u_parse (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .symbol       (s_tdata),
        .final_symbol (s_tlast),
        .req          (req),
        .status       (status)
    );

    // Row of map cells; results shift toward cell 0
    assign chain_w[NUM_CELLS] = '0;

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        ccb_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .req      (req),
            .shift    (shift),
            .shift_in (chain_w[k+1]),
            .word_out (chain_w[k])
        );
    end

    // Track result valid, word index and status
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            out_idx_reg   <= '0;
            status_reg    <= STATUS_OK;
        end else if (req.load) begin
            out_valid_reg <= 1'b1;
            out_idx_reg   <= '0;
            status_reg    <= status;
        end else if (drain_last) begin
            out_valid_reg <= 1'b0;
        end else if (shift) begin
            out_idx_reg <= out_idx_reg + 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = chain_w[0];
    assign m_tuser  = {status_reg, out_idx_reg};
    assign m_tlast  = (out_idx_reg == IDX_BITS'(NUM_CELLS - 1));

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        req.load |-> (!out_valid_reg || drain_last))
        else $error("map loaded over undelivered words");

    a_load_start: assert property (@(posedge aclk) disable iff (!aresetn)
        req.load |=> (m_tvalid && out_idx_reg == '0))
        else $error("loaded map does not start at word 0");

    a_idx_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (shift && !drain_last && !req.load) |=>
            (m_tvalid && out_idx_reg == $past(out_idx_reg) + 1'b1))
        else $error("word index did not advance");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && status_reg != STATUS_OK) |-> (m_tdata == '0))
        else $error("error status with nonzero map word");

endmodule
